// ===== rtl/core/flow_table_lookup_insert_age_defines.svh =====
// Assertion macros for the flow table block.
`ifndef FLOW_TABLE_LOOKUP_INSERT_AGE_DEFINES_SVH
`define FLOW_TABLE_LOOKUP_INSERT_AGE_DEFINES_SVH

`ifndef SYNTHESIS
`define FTLA_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define FTLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FTLA_ASSERT_SAME(label, ante, cons, msg)
`define FTLA_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== rtl/core/ftla_pkg.sv =====
// Types and constants shared by the flow table modules.
`timescale 1ns / 1ps
`default_nettype none

package ftla_pkg;

    localparam int TIME_W = 48;

    localparam logic [TIME_W-1:0] AGE_TIMEOUT_RST = 48'd1000000000;

    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_SWEEP  = 1'b1;

    localparam logic [8:0] AGED_MAX = 9'h1FF;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ftla_state_t;

    typedef enum logic [1:0] {
        STAT_HIT   = 2'd0,
        STAT_NEW   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_SWEEP = 2'd3
    } ftla_status_t;

    // One table entry as stored in the entry memory.
    typedef struct packed {
        logic              valid;
        logic [63:0]       addrs;        // src high, dst low
        logic [39:0]       ports_proto;  // src port, dst port, protocol
        logic [TIME_W-1:0] last_seen;
        logic [7:0]        in_port;
    } ftla_row_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic finish;
    } ftla_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic scan_end;
        logic out_free;
    } ftla_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftla_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module ftla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ftla_ctrl.sv =====
// Sequencer for the flow table: clearing pass, accept, scan and result.
`timescale 1ns / 1ps
`default_nettype none

module ftla_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    output ftla_pkg::ftla_cmd_t     cmd,
    input  wire ftla_pkg::ftla_stat_t stat
);

    ftla_pkg::ftla_state_t state_reg;
    ftla_pkg::ftla_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ftla_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ftla_pkg::ST_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = ftla_pkg::ST_IDLE;
                end
            end
            ftla_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ftla_pkg::ST_SCAN;
                end
            end
            ftla_pkg::ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.scan_end) begin
                    state_next = ftla_pkg::ST_FINISH;
                end
            end
            ftla_pkg::ST_FINISH: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ftla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ftla_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/ftla_dp.sv =====
// Flow table datapath: entry memory, scan pipeline, match, aging and result register.
`timescale 1ns / 1ps
`default_nettype none

module ftla_dp #(
    parameter int FLOW_ENTRIES = 256
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_we,
    input  wire logic [47:0]          cfg_wdata,
    input  wire logic                 s_tuser,
    input  wire logic [159:0]         s_tdata,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [1:0]                m_tuser,
    output logic [23:0]               m_tdata,
    input  wire ftla_pkg::ftla_cmd_t  cmd,
    output ftla_pkg::ftla_stat_t      stat
);

    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int ROW_W = $bits(ftla_pkg::ftla_row_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FLOW_ENTRIES - 1);

    logic [47:0]      timeout_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue_done_reg;
    logic             cmp_vld_reg;
    logic             out_vld_reg;

    logic             act_reg;
    logic [31:0]      src_addr_reg;
    logic [31:0]      dst_addr_reg;
    logic [15:0]      src_port_reg;
    logic [15:0]      dst_port_reg;
    logic [7:0]       proto_reg;
    logic [7:0]       in_port_reg;
    logic [47:0]      now_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             have_free_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [8:0]       aged_cnt_reg;

    ftla_pkg::ftla_status_t out_status_reg;
    logic [7:0]             out_index_reg;
    logic [8:0]             out_aged_reg;

    logic [ROW_W-1:0]     ram_rdata;
    logic [ROW_W-1:0]     ram_wdata;
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    ftla_pkg::ftla_row_t  row_rd;
    ftla_pkg::ftla_row_t  row_wr;

    logic [63:0]      fwd_a;
    logic [63:0]      rev_a;
    logic [39:0]      fwd_p;
    logic [39:0]      rev_p;
    logic             is_sweep;
    logic             key_match;
    logic [47:0]      age_diff;
    logic             hit_now;
    logic             aged_now;
    logic             free_now;
    logic             insert;
    logic [IDX_W+7:0] hit_idx_ext;
    logic [IDX_W+7:0] free_idx_ext;

    ftla_pkg::ftla_status_t res_status;
    logic [7:0]             res_index;
    logic [8:0]             res_aged;

    ftla_ram #(
        .WIDTH (ROW_W),
        .DEPTH (FLOW_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign row_rd    = ftla_pkg::ftla_row_t'(ram_rdata);
    assign ram_wdata = ROW_W'(row_wr);

    assign fwd_a = {src_addr_reg, dst_addr_reg};
    assign rev_a = {dst_addr_reg, src_addr_reg};
    assign fwd_p = {src_port_reg, dst_port_reg, proto_reg};
    assign rev_p = {dst_port_reg, src_port_reg, proto_reg};

    assign is_sweep  = (act_reg == ftla_pkg::ACT_SWEEP);
    assign key_match = ((row_rd.addrs == fwd_a) && (row_rd.ports_proto == fwd_p))
                    || ((row_rd.addrs == rev_a) && (row_rd.ports_proto == rev_p));
    assign age_diff  = now_reg - row_rd.last_seen;

    assign hit_now  = cmd.scan && cmp_vld_reg && !is_sweep && row_rd.valid && key_match;
    assign aged_now = cmd.scan && cmp_vld_reg && is_sweep && row_rd.valid
                   && (now_reg > row_rd.last_seen) && (age_diff > timeout_reg);
    assign free_now = cmd.scan && cmp_vld_reg && !is_sweep && !row_rd.valid && !have_free_reg;
    assign insert   = cmd.finish && !is_sweep && !hit_reg && have_free_reg;

    assign stat.clear_last = (rd_idx_reg == LAST_IDX);
    assign stat.hit        = hit_now;
    assign stat.scan_end   = cmp_vld_reg && (cmp_idx_reg == LAST_IDX);
    assign stat.out_free   = !out_vld_reg || m_tready;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg;
        row_wr    = '0;
        if (cmd.clear) begin
            ram_we = 1'b1;
        end else if (hit_now) begin
            ram_we           = 1'b1;
            ram_waddr        = cmp_idx_reg;
            row_wr           = row_rd;
            row_wr.last_seen = now_reg;
            row_wr.in_port   = in_port_reg;
        end else if (aged_now) begin
            ram_we       = 1'b1;
            ram_waddr    = cmp_idx_reg;
            row_wr       = row_rd;
            row_wr.valid = 1'b0;
        end else if (insert) begin
            ram_we             = 1'b1;
            ram_waddr          = free_idx_reg;
            row_wr.valid       = 1'b1;
            row_wr.addrs       = fwd_a;
            row_wr.ports_proto = fwd_p;
            row_wr.last_seen   = now_reg;
            row_wr.in_port     = in_port_reg;
        end
    end

    assign hit_idx_ext  = {8'd0, hit_idx_reg};
    assign free_idx_ext = {8'd0, free_idx_reg};

    always_comb begin
        res_index = 8'd0;
        res_aged  = 9'd0;
        if (is_sweep) begin
            res_status = ftla_pkg::STAT_SWEEP;
            res_aged   = aged_cnt_reg;
        end else if (hit_reg) begin
            res_status = ftla_pkg::STAT_HIT;
            res_index  = hit_idx_ext[7:0];
        end else if (have_free_reg) begin
            res_status = ftla_pkg::STAT_NEW;
            res_index  = free_idx_ext[7:0];
        end else begin
            res_status = ftla_pkg::STAT_FULL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg    <= ftla_pkg::AGE_TIMEOUT_RST;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
            if (cmd.clear) begin
                rd_idx_reg <= (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);
            end else if (cmd.load) begin
                rd_idx_reg     <= '0;
                issue_done_reg <= 1'b0;
                cmp_vld_reg    <= 1'b0;
            end else if (cmd.scan) begin
                cmp_vld_reg <= !issue_done_reg;
                if (!issue_done_reg) begin
                    if (rd_idx_reg == LAST_IDX) begin
                        issue_done_reg <= 1'b1;
                    end else begin
                        rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            if (cmd.finish) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            act_reg       <= s_tuser;
            src_addr_reg  <= s_tdata[31:0];
            dst_addr_reg  <= s_tdata[63:32];
            src_port_reg  <= s_tdata[79:64];
            dst_port_reg  <= s_tdata[95:80];
            proto_reg     <= s_tdata[103:96];
            in_port_reg   <= s_tdata[111:104];
            now_reg       <= s_tdata[159:112];
            have_free_reg <= 1'b0;
            hit_reg       <= 1'b0;
            aged_cnt_reg  <= 9'd0;
        end
        if (cmd.scan) begin
            cmp_idx_reg <= rd_idx_reg;
            if (free_now) begin
                have_free_reg <= 1'b1;
                free_idx_reg  <= cmp_idx_reg;
            end
            if (hit_now) begin
                hit_reg     <= 1'b1;
                hit_idx_reg <= cmp_idx_reg;
            end
            if (aged_now && (aged_cnt_reg != ftla_pkg::AGED_MAX)) begin
                aged_cnt_reg <= aged_cnt_reg + 9'd1;
            end
        end
        if (cmd.finish) begin
            out_status_reg <= res_status;
            out_index_reg  <= res_index;
            out_aged_reg   <= res_aged;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {7'd0, out_aged_reg, out_index_reg};

endmodule

`default_nettype wire

// ===== rtl/core/flow_table_lookup_insert_age.sv =====
// Top level of the five-tuple flow table with lookup, insert and aging.
// A packet beat is matched against the table in either direction; a hit refreshes the
// entry's last-seen time and input port, a miss fills the lowest free entry, and a full
// table drops the packet. A sweep beat frees every entry idle longer than age_timeout and
// reports the count. One beat is worked at a time: entries are read one per cycle from
// a single entry memory; a sweep or a miss reads every entry before the next accept,
// and a hit ends the scan at the matching entry. A result waits in an output register
// while the next beat is accepted. After reset the block runs a clearing pass over
// every entry of the memory before it accepts its first beat; age_timeout can be
// written meanwhile.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_table_lookup_insert_age_defines.svh"

module flow_table_lookup_insert_age #(
    parameter int FLOW_ENTRIES = 256
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_we,
    input  wire logic [47:0]  cfg_wdata,   // age_timeout
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // src_addr[31:0], dst_addr[63:32], src_port[79:64], dst_port[95:80],
    // proto_num[103:96], arrival_port[111:104], now_time[159:112]
    input  wire logic [159:0] s_tdata,
    input  wire logic         s_tuser,     // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [23:0]       m_tdata,     // flow_index[7:0], aged_count[16:8]
    output logic [1:0]        m_tuser      // status
);

    ftla_pkg::ftla_cmd_t  cmd;
    ftla_pkg::ftla_stat_t stat;

    ftla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    ftla_dp #(
        .FLOW_ENTRIES (FLOW_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

    `FTLA_ASSERT_SAME(a_cmd_excl, 1'b1, $onehot0(cmd), "conflicting datapath commands")
    `FTLA_ASSERT_SAME(a_finish_room, cmd.finish, stat.out_free, "result register overwritten")
    `FTLA_ASSERT_NEXT(a_load_scan, cmd.load, cmd.scan, "scan did not follow accepted beat")
    `FTLA_ASSERT_SAME(a_no_accept_clear, s_tvalid && s_tready, !cmd.clear, "beat in clear pass")

endmodule

`default_nettype wire
